// File: rtl/lr8_pkg.sv
// ----------------------------------------------------------------------------
// lr8_pkg: shared types for the eight-octant line rasterizer
// Octant codes; the last letter gives the major axis.
// ----------------------------------------------------------------------------
package lr8_pkg;

    typedef enum logic [2:0] {
        OCT_PX_PY_X = 3'd0,
        OCT_PX_PY_Y = 3'd1,
        OCT_PX_NY_Y = 3'd2,
        OCT_PX_NY_X = 3'd3,
        OCT_NX_NY_X = 3'd4,
        OCT_NX_NY_Y = 3'd5,
        OCT_NX_PY_Y = 3'd6,
        OCT_NX_PY_X = 3'd7
    } t_octant;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

endpackage

// File: rtl/lr8_req_if.sv
// ----------------------------------------------------------------------------
// lr8_req_if: request channel of the line rasterizer
// Start words carry both endpoints; step words ask for the next pixel.
// ----------------------------------------------------------------------------
interface lr8_req_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

// File: rtl/lr8_pix_if.sv
// ----------------------------------------------------------------------------
// lr8_pix_if: pixel channel of the line rasterizer
// One word per emitted pixel, flagged on the major-axis end.
// ----------------------------------------------------------------------------
interface lr8_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, last_pixel,
        output ready
    );
endinterface

// File: rtl/lr8_setup.sv
// ----------------------------------------------------------------------------
// lr8_setup: line setup
// Forms the deltas, classifies the octant and picks the major-axis end.
// ----------------------------------------------------------------------------
module lr8_setup
    import lr8_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic signed [COORD_BITS-1:0] i_x0,
    input  logic signed [COORD_BITS-1:0] i_y0,
    input  logic signed [COORD_BITS-1:0] i_x1,
    input  logic signed [COORD_BITS-1:0] i_y1,
    output logic signed [COORD_BITS:0]   o_dx,
    output logic signed [COORD_BITS:0]   o_dy,
    output t_octant                      o_octant,
    output logic signed [COORD_BITS-1:0] o_major_end
);
    localparam int C = COORD_BITS;

    logic signed [C:0]   dx;
    logic signed [C:0]   dy;
    logic signed [C+1:0] dx_w;
    logic signed [C+1:0] dy_w;
    logic signed [C+1:0] ndx_w;
    logic signed [C+1:0] ndy_w;
    t_octant             oct;

    always_comb begin
        dx    = {i_x1[C-1], i_x1} - {i_x0[C-1], i_x0};
        dy    = {i_y1[C-1], i_y1} - {i_y0[C-1], i_y0};
        dx_w  = {dx[C], dx};
        dy_w  = {dy[C], dy};
        ndx_w = -dx_w;
        ndy_w = -dy_w;
        if (dy[C] && !dx[C]) begin
            oct = (ndx_w > dy_w) ? OCT_PX_NY_Y : OCT_PX_NY_X;
        end else if (dy[C]) begin
            oct = (dx_w < dy_w) ? OCT_NX_NY_X : OCT_NX_NY_Y;
        end else if (dx[C]) begin
            oct = (dx_w > ndy_w) ? OCT_NX_PY_Y : OCT_NX_PY_X;
        end else begin
            oct = (dx_w > dy_w) ? OCT_PX_PY_X : OCT_PX_PY_Y;
        end
        case (oct) inside
            OCT_PX_PY_X, OCT_PX_NY_X, OCT_NX_NY_X, OCT_NX_PY_X: o_major_end = i_x1;
            default: o_major_end = i_y1;
        endcase
    end

    assign o_dx     = dx;
    assign o_dy     = dy;
    assign o_octant = oct;

endmodule

// File: rtl/lr8_step.sv
// ----------------------------------------------------------------------------
// lr8_step: pixel step
// Advances the major axis, updates the error sum and steps the minor axis.
// ----------------------------------------------------------------------------
module lr8_step
    import lr8_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  t_octant                      i_octant,
    input  logic signed [COORD_BITS-1:0] i_cur_x,
    input  logic signed [COORD_BITS-1:0] i_cur_y,
    input  logic signed [COORD_BITS+2:0] i_err,
    input  logic signed [COORD_BITS:0]   i_dx,
    input  logic signed [COORD_BITS:0]   i_dy,
    input  logic signed [COORD_BITS-1:0] i_major_end,
    output logic signed [COORD_BITS-1:0] o_next_x,
    output logic signed [COORD_BITS-1:0] o_next_y,
    output logic signed [COORD_BITS+2:0] o_next_err,
    output logic                         o_last
);
    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    logic signed [E-1:0] dx_e;
    logic signed [E-1:0] dy_e;
    logic signed [E-1:0] base;
    logic signed [E-1:0] corr;
    logic                x_major;
    logic                x_neg;
    logic                y_neg;
    logic                sel;
    logic                step_x;
    logic                step_y;
    logic [C-1:0]        x_inc;
    logic [C-1:0]        x_dec;
    logic [C-1:0]        y_inc;
    logic [C-1:0]        y_dec;

    always_comb begin
        dx_e = {{2{i_dx[C]}}, i_dx};
        dy_e = {{2{i_dy[C]}}, i_dy};
        case (i_octant)
            OCT_PX_PY_X: begin
                x_major = 1'b1; x_neg = 1'b0; y_neg = 1'b0; base = dy_e;  corr = -dx_e;
            end
            OCT_PX_PY_Y: begin
                x_major = 1'b0; x_neg = 1'b0; y_neg = 1'b0; base = dx_e;  corr = -dy_e;
            end
            OCT_PX_NY_Y: begin
                x_major = 1'b0; x_neg = 1'b0; y_neg = 1'b1; base = dx_e;  corr = dy_e;
            end
            OCT_PX_NY_X: begin
                x_major = 1'b1; x_neg = 1'b0; y_neg = 1'b1; base = -dy_e; corr = -dx_e;
            end
            OCT_NX_NY_X: begin
                x_major = 1'b1; x_neg = 1'b1; y_neg = 1'b1; base = dy_e;  corr = -dx_e;
            end
            OCT_NX_NY_Y: begin
                x_major = 1'b0; x_neg = 1'b1; y_neg = 1'b1; base = dx_e;  corr = -dy_e;
            end
            OCT_NX_PY_Y: begin
                x_major = 1'b0; x_neg = 1'b1; y_neg = 1'b0; base = dx_e;  corr = dy_e;
            end
            default: begin
                x_major = 1'b1; x_neg = 1'b1; y_neg = 1'b0; base = -dy_e; corr = -dx_e;
            end
        endcase

        // minor step when the error sum has passed zero
        sel    = x_neg ? i_err[E-1] : (!i_err[E-1] && (i_err != '0));
        step_x = x_major || sel;
        step_y = !x_major || sel;

        x_inc = i_cur_x + C'(1);
        x_dec = i_cur_x - C'(1);
        y_inc = i_cur_y + C'(1);
        y_dec = i_cur_y - C'(1);

        o_next_x   = step_x ? (x_neg ? x_dec : x_inc) : i_cur_x;
        o_next_y   = step_y ? (y_neg ? y_dec : y_inc) : i_cur_y;
        o_next_err = i_err + base + (sel ? corr : '0);
        o_last     = x_major ? (i_cur_x == i_major_end) : (i_cur_y == i_major_end);
    end

endmodule

// File: rtl/line_rasterizer_eight_octant_core.sv
// ----------------------------------------------------------------------------
// line_rasterizer_eight_octant_core: eight-octant integer line rasterizer
//
// Request channel i_req takes two kinds of word. A start word (req_type 0)
// loads both endpoints, classifies the octant and arms the line; it gives
// no pixel. Each step word (req_type 1) gives one pixel on o_pix, the
// start point first, then one per major-axis step; the pixel on the
// major-axis end carries last_pixel and disarms the line. A step word
// while no line is armed is consumed and gives nothing. A start word while
// a line is armed drops that line.
// A pixel appears on o_pix in the cycle after its step word is taken.
// Throughput: one word per cycle while i_req.ready is high; the line state
// updates through combinational adds and compares on the registered error sum.
// The pixel output register frees in the same cycle it is drained, so
// i_req.ready is low only while a pixel is held and o_pix.ready is low.
// Reset (synchronous, active low) disarms the line and empties the output.
// ----------------------------------------------------------------------------
module line_rasterizer_eight_octant_core
    import lr8_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lr8_req_if.sink   i_req,
    lr8_pix_if.source o_pix
);
    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    logic                r_active;
    logic signed [C-1:0] r_cur_x;
    logic signed [C-1:0] r_cur_y;
    logic signed [E-1:0] r_err;
    logic signed [C:0]   r_dx;
    logic signed [C:0]   r_dy;
    logic signed [C-1:0] r_major_end;
    t_octant             r_octant;
    logic                r_out_valid;
    logic signed [C-1:0] r_pix_x;
    logic signed [C-1:0] r_pix_y;
    logic                r_last;

    logic                n_out_valid;
    logic                w_accept;
    logic                w_start;
    logic                w_emit;

    logic signed [C:0]   s_dx;
    logic signed [C:0]   s_dy;
    t_octant             s_octant;
    logic signed [C-1:0] s_major_end;

    logic signed [C-1:0] p_next_x;
    logic signed [C-1:0] p_next_y;
    logic signed [E-1:0] p_next_err;
    logic                p_last;

    lr8_setup #(.COORD_BITS(C)) u_setup (
        .i_x0        (i_req.start_x),
        .i_y0        (i_req.start_y),
        .i_x1        (i_req.end_x),
        .i_y1        (i_req.end_y),
        .o_dx        (s_dx),
        .o_dy        (s_dy),
        .o_octant    (s_octant),
        .o_major_end (s_major_end)
    );

    lr8_step #(.COORD_BITS(C)) u_step (
        .i_octant    (r_octant),
        .i_cur_x     (r_cur_x),
        .i_cur_y     (r_cur_y),
        .i_err       (r_err),
        .i_dx        (r_dx),
        .i_dy        (r_dy),
        .i_major_end (r_major_end),
        .o_next_x    (p_next_x),
        .o_next_y    (p_next_y),
        .o_next_err  (p_next_err),
        .o_last      (p_last)
    );

    assign i_req.ready = !r_out_valid || o_pix.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_start     = w_accept && (i_req.req_type == REQ_START);
    assign w_emit      = w_accept && (i_req.req_type == REQ_STEP) && r_active;

    always_comb begin
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_err       <= '0;
            r_dx        <= '0;
            r_dy        <= '0;
            r_octant    <= OCT_PX_PY_X;
            r_major_end <= '0;
            r_pix_x     <= '0;
            r_pix_y     <= '0;
            r_last      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_start) begin
                r_active <= 1'b1;
            end else if (w_emit && p_last) begin
                r_active <= 1'b0;
            end
            if (w_start) begin
                r_cur_x     <= i_req.start_x;
                r_cur_y     <= i_req.start_y;
                r_err       <= '0;
                r_dx        <= s_dx;
                r_dy        <= s_dy;
                r_octant    <= s_octant;
                r_major_end <= s_major_end;
            end else if (w_emit) begin
                r_cur_x <= p_next_x;
                r_cur_y <= p_next_y;
                r_err   <= p_next_err;
            end
            if (w_emit) begin
                r_pix_x <= r_cur_x;
                r_pix_y <= r_cur_y;
                r_last  <= p_last;
            end
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_x    = r_pix_x;
    assign o_pix.pixel_y    = r_pix_y;
    assign o_pix.last_pixel = r_last;

    a_pix_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_emit))
        else $error("pixel word without an accepted step");

    a_last_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && p_last && !w_start) |=> !r_active)
        else $error("line still armed after last pixel");

    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_active && (r_err == '0) && !$rose(r_out_valid)))
        else $error("start word did not arm a clean line");

    a_idle_step_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.req_type == REQ_STEP) && !r_active)
        |=> ($stable(r_cur_x) && $stable(r_cur_y) && !r_active))
        else $error("idle step changed line state");

endmodule

// File: bench/line_rasterizer_eight_octant_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_eight_octant_checker: pixel checker for the line rasterizer
// Follows every word taken on the request channel with its own line stepper,
// queues the pixel each step word should give, and compares every pixel
// taken on the output channel against the oldest one queued.
// ----------------------------------------------------------------------------
module line_rasterizer_eight_octant_checker
    import lr8_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lr8_req_if   i_req,
    lr8_pix_if   i_pix,
    output int   o_fail_count,
    output int   o_pending
);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last_pixel;
    } t_pixel;

    t_pixel                       expected_pixels[$];
    logic                         line_armed;
    t_coord                       pos_x;
    t_coord                       pos_y;
    t_coord                       major_stop;
    logic signed [COORD_BITS+2:0] err_acc;
    logic signed [COORD_BITS:0]   run_x;
    logic signed [COORD_BITS:0]   run_y;
    t_octant                      octant;
    int                           mismatches;

    function automatic void arm_line(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        logic signed [COORD_BITS:0] dx;
        logic signed [COORD_BITS:0] dy;
        dx = ex - sx;
        dy = ey - sy;
        if (ey < sy && ex >= sx) begin
            octant = (-dx > dy) ? OCT_PX_NY_Y : OCT_PX_NY_X;
        end else if (ey < sy) begin
            octant = (dx < dy) ? OCT_NX_NY_X : OCT_NX_NY_Y;
        end else if (ex < sx) begin
            octant = (dx > -dy) ? OCT_NX_PY_Y : OCT_NX_PY_X;
        end else begin
            octant = (dx > dy) ? OCT_PX_PY_X : OCT_PX_PY_Y;
        end
        run_x      = dx;
        run_y      = dy;
        pos_x      = sx;
        pos_y      = sy;
        err_acc    = '0;
        major_stop = (octant inside {OCT_PX_PY_X, OCT_PX_NY_X, OCT_NX_NY_X, OCT_NX_PY_X})
                     ? ex : ey;
        line_armed = 1'b1;
    endfunction

    function automatic logic plot_next(output t_pixel pix);
        int   d;
        int   ix;
        int   iy;
        logic adv;
        pix = '0;
        if (!line_armed) return 1'b0;
        d     = err_acc;
        ix    = run_x;
        iy    = run_y;
        pix.x = pos_x;
        pix.y = pos_y;
        case (octant)
            OCT_PX_PY_X: begin
                pix.last_pixel = (pos_x == major_stop);
                adv = (d > 0);
                d += adv ? iy - ix : iy;
                pos_x = pos_x + 1'b1;
                if (adv) pos_y = pos_y + 1'b1;
            end
            OCT_PX_PY_Y: begin
                pix.last_pixel = (pos_y == major_stop);
                adv = (d > 0);
                d += adv ? ix - iy : ix;
                pos_y = pos_y + 1'b1;
                if (adv) pos_x = pos_x + 1'b1;
            end
            OCT_PX_NY_Y: begin
                pix.last_pixel = (pos_y == major_stop);
                adv = (d > 0);
                d += adv ? ix + iy : ix;
                pos_y = pos_y - 1'b1;
                if (adv) pos_x = pos_x + 1'b1;
            end
            OCT_PX_NY_X: begin
                pix.last_pixel = (pos_x == major_stop);
                adv = (d > 0);
                d += adv ? -iy - ix : -iy;
                pos_x = pos_x + 1'b1;
                if (adv) pos_y = pos_y - 1'b1;
            end
            OCT_NX_NY_X: begin
                pix.last_pixel = (pos_x == major_stop);
                adv = (d < 0);
                d += adv ? iy - ix : iy;
                pos_x = pos_x - 1'b1;
                if (adv) pos_y = pos_y - 1'b1;
            end
            OCT_NX_NY_Y: begin
                pix.last_pixel = (pos_y == major_stop);
                adv = (d < 0);
                d += adv ? ix - iy : ix;
                pos_y = pos_y - 1'b1;
                if (adv) pos_x = pos_x - 1'b1;
            end
            OCT_NX_PY_Y: begin
                pix.last_pixel = (pos_y == major_stop);
                adv = (d < 0);
                d += adv ? ix + iy : ix;
                pos_y = pos_y + 1'b1;
                if (adv) pos_x = pos_x - 1'b1;
            end
            default: begin
                pix.last_pixel = (pos_x == major_stop);
                adv = (d < 0);
                d += adv ? -ix - iy : -iy;
                pos_x = pos_x - 1'b1;
                if (adv) pos_y = pos_y + 1'b1;
            end
        endcase
        err_acc = d;
        if (pix.last_pixel) line_armed = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pixel want;
        t_pixel got;
        if (!i_rst_n) begin
            line_armed = 1'b0;
            pos_x      = '0;
            pos_y      = '0;
            major_stop = '0;
            err_acc    = '0;
            run_x      = '0;
            run_y      = '0;
            octant     = OCT_PX_PY_X;
            mismatches = 0;
            expected_pixels.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                if (i_req.req_type == REQ_START) begin
                    arm_line(i_req.start_x, i_req.start_y, i_req.end_x, i_req.end_y);
                end else if (plot_next(want)) begin
                    expected_pixels.push_back(want);
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                got.x          = i_pix.pixel_x;
                got.y          = i_pix.pixel_y;
                got.last_pixel = i_pix.last_pixel;
                if (expected_pixels.size() == 0) begin
                    if (mismatches < 10)
                        $display("checker: unexpected pixel (%0d, %0d) last %0b",
                                 got.x, got.y, got.last_pixel);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.x !== want.x || got.y !== want.y ||
                            got.last_pixel !== want.last_pixel) begin
                        if (mismatches < 10)
                            $display({"checker: pixel mismatch, expected (%0d, %0d) ",
                                      "last %0b, got (%0d, %0d) last %0b"},
                                     want.x, want.y, want.last_pixel,
                                     got.x, got.y, got.last_pixel);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_pixels.size();
    end

endmodule

// File: bench/line_rasterizer_eight_octant_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_eight_octant_core_tb: testbench of the line rasterizer
// Draws a directed set of lines, one per octant plus a single-point line and
// stray step words, then random lines of mostly short length, some cut off
// by a new start. Both channels idle at random, and the pixel side holds off
// once for a long stretch; a separate checker compares every pixel.
// ----------------------------------------------------------------------------
module line_rasterizer_eight_octant_core_tb;
    import lr8_pkg::*;

    localparam int COORD_BITS   = 12;
    localparam int COORD_MAX    = 2 ** (COORD_BITS - 1) - 1;
    localparam int COORD_MIN    = -(2 ** (COORD_BITS - 1));
    localparam int RANDOM_WORDS = 1200;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 400000;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct {
        int sx;
        int sy;
        int ex;
        int ey;
    } t_segment;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic hold_pix;
    int   fail_count;
    int   pending;
    int   cycles;
    int   words_sent;
    int   words_counted;
    int   pixels_left;
    int   send_stretch;
    int   drain_stretch;
    bit   send_steady;
    bit   drain_steady;

    t_segment octant_lines[8] = '{
        '{-2048, -2048, -2047, -2048},
        '{  100,    -5,   101,    -4},
        '{-2048,  2047, -2048,  2046},
        '{ 2046,     0,  2047,    -1},
        '{ 2047,  2047,  2045,  2046},
        '{ -300,     7,  -301,     6},
        '{ 2047, -2048,  2046, -2046},
        '{    0,  2047,    -1,  2047}
    };

    lr8_req_if #(.COORD_BITS(COORD_BITS)) req_ch();
    lr8_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch();

    line_rasterizer_eight_octant_core #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_pix  (pix_ch)
    );

    line_rasterizer_eight_octant_checker #(
        .COORD_BITS(COORD_BITS)
    ) pixel_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_pix       (pix_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int draw_wait(inout int stretch, inout bit steady);
        if (stretch == 0) begin
            stretch = $urandom_range(10, 60);
            steady  = ($urandom_range(0, 3) == 0);
        end
        stretch--;
        return steady ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
    endfunction

    function automatic int clamp_coord(int v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    task automatic send_word(logic kind, int sx, int sy, int ex, int ey);
        int gap;
        int dx;
        int dy;
        gap = draw_wait(send_stretch, send_steady);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.start_x  <= t_coord'(sx);
        req_ch.start_y  <= t_coord'(sy);
        req_ch.end_x    <= t_coord'(ex);
        req_ch.end_y    <= t_coord'(ey);
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        words_sent++;
        if (kind == REQ_START) begin
            dx = ex - sx;
            dy = ey - sy;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            pixels_left = ((dx > dy) ? dx : dy) + 1;
            words_counted++;
        end else if (pixels_left != 0) begin
            pixels_left--;
            words_counted++;
        end
    endtask

    // steps < 0: step through to the last pixel
    task automatic trace_line(int sx, int sy, int ex, int ey, int steps);
        send_word(REQ_START, sx, sy, ex, ey);
        if (steps < 0) steps = pixels_left;
        repeat (steps) send_word(REQ_STEP, any_coord(), any_coord(), any_coord(), any_coord());
    endtask

    initial begin : drain
        int stall_left;
        stall_left = 0;
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pix_ch.valid && pix_ch.ready) stall_left = draw_wait(drain_stretch, drain_steady);
            if (hold_pix || stall_left != 0) begin
                pix_ch.ready <= 1'b0;
                if (stall_left != 0) stall_left--;
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : long_hold
        hold_pix <= 1'b0;
        wait (words_sent >= 200);
        @(posedge i_clk);
        hold_pix <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_pix <= 1'b0;
    end

    initial begin : stimulus
        int sx;
        int sy;
        int ex;
        int ey;
        int reach;
        int pick;
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_STEP;
        req_ch.start_x  <= '0;
        req_ch.start_y  <= '0;
        req_ch.end_x    <= '0;
        req_ch.end_y    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(REQ_STEP, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        trace_line(0, 0, 0, 0, -1);
        send_word(REQ_STEP, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        foreach (octant_lines[i])
            trace_line(octant_lines[i].sx, octant_lines[i].sy,
                       octant_lines[i].ex, octant_lines[i].ey, -1);

        words_counted = 0;
        while (words_counted < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                case ($urandom_range(0, 99)) inside
                    [0:4]:   reach = 0;
                    [5:5]:   reach = 300;
                    [6:29]:  reach = 60;
                    default: reach = 12;
                endcase
                sx = any_coord();
                sy = any_coord();
                ex = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
                ey = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
                trace_line(sx, sy, ex, ey,
                           ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 6)) : -1);
            end else if (pick < 90) begin
                trace_line(any_coord(), any_coord(), any_coord(), any_coord(),
                           int'($urandom_range(0, 4)));
            end else begin
                repeat ($urandom_range(1, 3))
                    send_word(REQ_STEP, any_coord(), any_coord(), any_coord(), any_coord());
            end
        end

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/lr8_pkg.sv
rtl/lr8_req_if.sv
rtl/lr8_pix_if.sv
rtl/lr8_setup.sv
rtl/lr8_step.sv
rtl/line_rasterizer_eight_octant_core.sv
bench/line_rasterizer_eight_octant_checker.sv
bench/line_rasterizer_eight_octant_core_tb.sv
